// File: rtl/linear_probe_hash_table_top_defines.svh
// Assertion macros shared by the hash table RTL.
// Included by the front end, queue, back end and top level; needs nothing else.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPHT_AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPHT_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpht_pkg.sv
// Shared widths and codes for the linear probing hash table.
// No dependencies; imported by the front end, back end and top level.
package lpht_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int BYTE_W    = 8;
  localparam int KEY_BYTES_MAX = 8;
  // Sum of eight bytes is at most 2040.
  localparam int SUM_W     = 11;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// File: rtl/lpht_front.sv
// Request front end: key cleanup, byte sum and reciprocal hash reduction.
// Depends on lpht_pkg and the shared assertion macros.
`include "linear_probe_hash_table_top_defines.svh"

module lpht_front import lpht_pkg::*; #(
  parameter int TABLE_SLOTS  = 30,
  parameter int HASH_MODULUS = 29,
  parameter int KEY_BYTES    = 8,
  parameter int SLOT_W       = $clog2(TABLE_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [KEY_W-1:0]  in_lookup_key,
  input  logic [VAL_W-1:0]  in_record_value,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [KIND_W-1:0] push_kind,
  output logic [KEY_W-1:0]  push_key,
  output logic [VAL_W-1:0]  push_val,
  output logic [SLOT_W-1:0] push_home
);

  // Rounded-up reciprocals; exact for dividends below 2^11 and divisors 2 to 1024.
  localparam int RCP_S  = 22;
  localparam int PROD_W = SUM_W + RCP_S;
  localparam logic [RCP_S-1:0] RCP_HM = RCP_S'((2**RCP_S + HASH_MODULUS - 1) / HASH_MODULUS);
  localparam logic [RCP_S-1:0] RCP_TS = RCP_S'((2**RCP_S + TABLE_SLOTS - 1) / TABLE_SLOTS);
  localparam logic [SUM_W-1:0] HM_DIV = SUM_W'(HASH_MODULUS);
  localparam logic [SUM_W-1:0] TS_DIV = SUM_W'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MOD1 = 4'b0010,
    F_MOD2 = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t      state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic              step_r, step_nxt;

  logic [KEY_W-1:0]  norm_key;
  logic [SUM_W-1:0]  byte_sum;
  logic [SUM_W-1:0]  dividend;
  logic [RCP_S-1:0]  recip;
  logic [SUM_W-1:0]  divisor;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  back_prod;
  logic [SUM_W-1:0]  rem_new;

  // Keep bytes below the first zero byte and within KEY_BYTES; sum them.
  always_comb begin
    logic              alive;
    logic [BYTE_W-1:0] cur_byte;
    alive    = 1'b1;
    norm_key = '0;
    byte_sum = '0;
    for (int b = 0; b < KEY_BYTES_MAX; b++) begin
      cur_byte = in_lookup_key[BYTE_W*b +: BYTE_W];
      if (b < KEY_BYTES && alive && (cur_byte != '0)) begin
        norm_key[BYTE_W*b +: BYTE_W] = cur_byte;
        byte_sum = byte_sum + SUM_W'(cur_byte);
      end else begin
        alive = 1'b0;
      end
    end
  end

  // Each reduction: quotient by reciprocal multiply, then remainder next cycle.
  assign dividend  = (state_r == F_MOD1) ? sum_r : rem_r;
  assign recip     = (state_r == F_MOD1) ? RCP_HM : RCP_TS;
  assign divisor   = (state_r == F_MOD1) ? HM_DIV : TS_DIV;
  assign prod      = PROD_W'(dividend) * PROD_W'(recip);
  assign back_prod = quo_r * divisor;
  assign rem_new   = dividend - back_prod;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    sum_nxt   = sum_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = norm_key;
          val_nxt   = in_record_value;
          sum_nxt   = byte_sum;
          step_nxt  = 1'b0;
          state_nxt = F_MOD1;
        end
      end
      F_MOD1: begin
        if (!step_r) begin
          quo_nxt  = prod[PROD_W-1:RCP_S];
          step_nxt = 1'b1;
        end else begin
          rem_nxt   = rem_new;
          step_nxt  = 1'b0;
          state_nxt = F_MOD2;
        end
      end
      F_MOD2: begin
        if (!step_r) begin
          quo_nxt  = prod[PROD_W-1:RCP_S];
          step_nxt = 1'b1;
        end else begin
          rem_nxt   = rem_new;
          step_nxt  = 1'b0;
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    sum_r  <= sum_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_kind  = kind_r;
  assign push_key   = key_r;
  assign push_val   = val_r;
  assign push_home  = rem_r[SLOT_W-1:0];

  `LPHT_AST_NOW(a_home_in_range, clk, rst_n, push_valid, rem_r < TS_DIV, "home slot out of range")

endmodule

// File: rtl/lpht_queue.sv
// Two-entry queue that decouples the hash front end from the table back end.
// Depends on the shared assertion macros only.
`include "linear_probe_hash_table_top_defines.svh"

module lpht_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  `LPHT_AST_NOW(a_count_bound, clk, rst_n, 1'b1, count_r != 2'd3, "queue overfilled")

endmodule

// File: rtl/lpht_back.sv
// Table back end: slot store, probe sequencer, backward-shift delete, result register.
// Depends on lpht_pkg and the shared assertion macros.
`include "linear_probe_hash_table_top_defines.svh"

module lpht_back import lpht_pkg::*; #(
  parameter int TABLE_SLOTS = 30,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic [KIND_W-1:0]   q_kind,
  input  logic [KEY_W-1:0]    q_key,
  input  logic [VAL_W-1:0]    q_val,
  input  logic [SLOT_W-1:0]   q_home,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot_index,
  output logic [VAL_W-1:0]    out_found_value
);

  localparam logic [SLOT_W-1:0] LAST   = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W:0]   TS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_PROBE = 4'b0010,
    B_SHIFT = 4'b0100,
    B_DONE  = 4'b1000
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic [TABLE_SLOTS-1:0] used_r, used_nxt;
  logic [KIND_W-1:0]   op_kind_r, op_kind_nxt;
  logic [KEY_W-1:0]    op_key_r, op_key_nxt;
  logic [VAL_W-1:0]    op_val_r, op_val_nxt;
  logic [SLOT_W-1:0]   op_home_r, op_home_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]   hole_r, hole_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [VAL_W-1:0]    res_value_r, res_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;

  // Slot store: one write port, one registered read port.
  logic [KEY_W-1:0]    mem_key  [TABLE_SLOTS];
  logic [VAL_W-1:0]    mem_val  [TABLE_SLOTS];
  logic [SLOT_W-1:0]   mem_home [TABLE_SLOTS];
  logic [KEY_W-1:0]    rd_key_r;
  logic [VAL_W-1:0]    rd_val_r;
  logic [SLOT_W-1:0]   rd_home_r;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [KEY_W-1:0]    wr_key;
  logic [VAL_W-1:0]    wr_val;
  logic [SLOT_W-1:0]   wr_home;

  logic [SLOT_W-1:0]   cur_next;
  logic [SLOT_W:0]     dist_home;
  logic [SLOT_W:0]     dist_hole;

  assign cur_next = (cur_r == LAST) ? '0 : cur_r + 1'b1;

  // Cyclic distances from the stored entry's home and from the hole.
  assign dist_home = (cur_r >= rd_home_r) ? {1'b0, cur_r - rd_home_r}
                                          : {1'b0, cur_r} + TS_EXT - {1'b0, rd_home_r};
  assign dist_hole = (cur_r >= hole_r) ? {1'b0, cur_r - hole_r}
                                       : {1'b0, cur_r} + TS_EXT - {1'b0, hole_r};

  // Read one slot ahead so every cycle examines a fresh slot.
  assign rd_addr = (state_r == B_IDLE) ? q_home : cur_next;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    op_kind_nxt    = op_kind_r;
    op_key_nxt     = op_key_r;
    op_val_nxt     = op_val_r;
    op_home_nxt    = op_home_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    hole_nxt       = hole_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_value_nxt  = out_value_r;
    q_ready        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_key         = op_key_r;
    wr_val         = op_val_r;
    wr_home        = op_home_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_ready        = 1'b1;
          op_kind_nxt    = q_kind;
          op_key_nxt     = q_key;
          op_val_nxt     = q_val;
          op_home_nxt    = q_home;
          cur_nxt        = q_home;
          cnt_nxt        = '0;
          res_status_nxt = ST_MISS;
          res_slot_nxt   = '0;
          res_value_nxt  = '0;
          if (q_kind == KIND_INSERT || q_kind == KIND_SEARCH || q_kind == KIND_DELETE) begin
            state_nxt = B_PROBE;
          end else begin
            state_nxt = B_DONE;
          end
        end
      end
      B_PROBE: begin
        case (op_kind_r)
          KIND_INSERT: begin
            if (!used_r[cur_r]) begin
              wr_en          = 1'b1;
              used_nxt[cur_r] = 1'b1;
              res_status_nxt = ST_OK;
              res_slot_nxt   = cur_r;
              state_nxt      = B_DONE;
            end else if (cnt_r == LAST) begin
              res_status_nxt = ST_FULL;
              state_nxt      = B_DONE;
            end else begin
              cur_nxt = cur_next;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          default: begin
            if (!used_r[cur_r]) begin
              state_nxt = B_DONE;
            end else if (rd_key_r == op_key_r) begin
              res_status_nxt = ST_OK;
              res_slot_nxt   = cur_r;
              if (op_kind_r == KIND_SEARCH) begin
                res_value_nxt = rd_val_r;
                state_nxt     = B_DONE;
              end else begin
                // Free the slot, then walk the rest of the cluster.
                used_nxt[cur_r] = 1'b0;
                hole_nxt        = cur_r;
                cur_nxt         = cur_next;
                cnt_nxt         = SLOT_W'(1);
                state_nxt       = B_SHIFT;
              end
            end else if (cnt_r == LAST) begin
              state_nxt = B_DONE;
            end else begin
              cur_nxt = cur_next;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        endcase
      end
      B_SHIFT: begin
        if (!used_r[cur_r]) begin
          state_nxt = B_DONE;
        end else begin
          if (dist_home >= dist_hole) begin
            // Pull the entry back into the hole.
            wr_en            = 1'b1;
            wr_addr          = hole_r;
            wr_key           = rd_key_r;
            wr_val           = rd_val_r;
            wr_home          = rd_home_r;
            used_nxt[hole_r] = 1'b1;
            used_nxt[cur_r]  = 1'b0;
            hole_nxt         = cur_r;
          end
          if (cnt_r == LAST) begin
            state_nxt = B_DONE;
          end else begin
            cur_nxt = cur_next;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_value_nxt  = res_value_r;
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_kind_r    <= op_kind_nxt;
    op_key_r     <= op_key_nxt;
    op_val_r     <= op_val_nxt;
    op_home_r    <= op_home_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    hole_r       <= hole_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]  <= wr_key;
      mem_val[wr_addr]  <= wr_val;
      mem_home[wr_addr] <= wr_home;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r  <= mem_key[rd_addr];
    rd_val_r  <= mem_val[rd_addr];
    rd_home_r <= mem_home[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_found_value = out_value_r;

  `LPHT_AST_NOW(a_hole_behind_scan, clk, rst_n, state_r == B_SHIFT, hole_r != cur_r, "hole meets scan")
  `LPHT_AST_NEXT(a_write_sets_used, clk, rst_n, wr_en, used_r[$past(wr_addr)], "written slot not used")
  `LPHT_AST_NOW(a_fail_zero_payload, clk, rst_n, state_r == B_DONE && res_status_r != ST_OK, res_slot_r == '0 && res_value_r == '0, "failed request carries payload")

endmodule

// File: rtl/linear_probe_hash_table_top.sv
// Top level of the linear probing hash table: front end, queue and back end.
// Depends on lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
// Usage: one request beat on the in_ channel (insert, search or delete of a
// key of up to eight bytes, zero padded) yields exactly one result beat on
// the out_ channel: status, slot index and found value, in request order.
// The result beat follows the request beat through two hash reductions (sum
// mod HASH_MODULUS, then mod TABLE_SLOTS), each a quotient step then a
// remainder step; the push into the queue; the pop into the back end; the
// probe of 1 to TABLE_SLOTS slots; for a delete, the backward shift of 0 to
// TABLE_SLOTS - 1 slots; and the load of the result register.
// Throughput: the front end takes a new beat only after pushing the last one;
// the back end takes a new request only after loading the last result; the
// slower side sets the rate.
// Reset clears every slot's used bit at once; no clearing pass is needed.
// When the receiver stalls, hold the result in the output register; the
// back end finishes its next request and waits, the two-entry queue fills,
// then the front end drops in_ready.
`include "linear_probe_hash_table_top_defines.svh"

module linear_probe_hash_table_top import lpht_pkg::*; #(
  parameter int TABLE_SLOTS  = 30,
  parameter int HASH_MODULUS = 29,
  parameter int KEY_BYTES    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [KIND_W-1:0]               in_kind,
  input  logic [KEY_W-1:0]                in_lookup_key,
  input  logic [VAL_W-1:0]                in_record_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic [$clog2(TABLE_SLOTS)-1:0]  out_slot_index,
  output logic [VAL_W-1:0]                out_found_value
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int Q_W    = KIND_W + KEY_W + VAL_W + SLOT_W;

  // Front end to queue.
  logic              f_valid;
  logic              f_ready;
  logic [KIND_W-1:0] f_kind;
  logic [KEY_W-1:0]  f_key;
  logic [VAL_W-1:0]  f_val;
  logic [SLOT_W-1:0] f_home;

  // Queue to back end.
  logic              b_valid;
  logic              b_ready;
  logic [Q_W-1:0]    b_data;
  logic [KIND_W-1:0] b_kind;
  logic [KEY_W-1:0]  b_key;
  logic [VAL_W-1:0]  b_val;
  logic [SLOT_W-1:0] b_home;

  // Clean the key and reduce its byte sum to a home slot.
  lpht_front #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .HASH_MODULUS (HASH_MODULUS),
    .KEY_BYTES    (KEY_BYTES),
    .SLOT_W       (SLOT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_lookup_key   (in_lookup_key),
    .in_record_value (in_record_value),
    .push_valid      (f_valid),
    .push_ready      (f_ready),
    .push_kind       (f_kind),
    .push_key        (f_key),
    .push_val        (f_val),
    .push_home       (f_home)
  );

  // Decouple hashing from table work.
  lpht_queue #(
    .W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_kind, f_key, f_val, f_home}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  assign {b_kind, b_key, b_val, b_home} = b_data;

  // Probe, modify the table and present the result.
  lpht_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (b_valid),
    .q_ready         (b_ready),
    .q_kind          (b_kind),
    .q_key           (b_key),
    .q_val           (b_val),
    .q_home          (b_home),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_found_value (out_found_value)
  );

endmodule
